/* rtl/cel_pkg.sv */
// cel_pkg: shared types and constants of the cross-entropy loss row unit
// no dependencies

package cel_pkg;

   // payload of one input item
   typedef struct packed {
      logic [15:0] pred_prob;
      logic [15:0] target;
      logic        row_last;
   } cel_req_type;

   // payload of one result item
   typedef struct packed {
      logic [19:0] loss;
      logic        zero_confidence;
   } cel_rsp_type;

   // log unit sequencer states
   typedef enum logic [2:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQUARE,
      LOG_SUB,
      LOG_MUL,
      LOG_ROUND,
      LOG_DONE
   } cel_log_state_type;

   localparam int          CONF_W      = 32;
   localparam int          FRAC_BITS   = 24;
   localparam int          QUEUE_DEPTH = 4;
   localparam logic [31:0] LN2_Q32     = 32'd2977044472;
   localparam logic [19:0] LOSS_MAX    = 20'hFFFFF;

endpackage

/* rtl/cel_front.sv */
// cel_front: per-row confidence accumulator, one column per cycle while accept is high
// depends on cel_pkg

module cel_front
   import cel_pkg::*;
#(
   parameter int MAX_CLASSES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sparse_labels,
   input  logic                accept,
   input  cel_req_type         item,
   output logic                conf_push,
   output logic [CONF_W-1:0]   conf_data
);

   localparam int CW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
   localparam logic [CW-1:0] COL_LAST = CW'(MAX_CLASSES - 1);

   logic [CW-1:0]     col_count_ff, col_count_in;
   logic [CONF_W-1:0] acc_ff, acc_in;
   logic [15:0]       pred_clip;
   logic [31:0]       product;
   logic [32:0]       dense_sum;
   logic [CONF_W-1:0] acc_next;

   // clip zero to one lsb
   assign pred_clip = (item.pred_prob == 16'd0) ? 16'd1 : item.pred_prob;
   assign product   = 32'(pred_clip) * 32'(item.target);
   assign dense_sum = 33'(acc_ff) + 33'(product);

   // accumulate or select the confidence of this column
   always_comb begin
      acc_next = acc_ff;
      if (sparse_labels) begin
         if (item.target == 16'(col_count_ff)) begin
            acc_next = {pred_clip, 16'd0};
         end
      end else begin
         acc_next = dense_sum[32] ? '1 : dense_sum[31:0];
      end
   end

   // row state update
   always_comb begin
      col_count_in = col_count_ff;
      acc_in       = acc_ff;
      if (accept) begin
         if (item.row_last) begin
            col_count_in = '0;
            acc_in       = '0;
         end else begin
            col_count_in = (col_count_ff == COL_LAST) ? '0 : col_count_ff + 1'b1;
            acc_in       = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         acc_ff       <= '0;
      end else begin
         col_count_ff <= col_count_in;
         acc_ff       <= acc_in;
      end
   end

   // hand the finished row confidence to the queue
   assign conf_push = accept & item.row_last;
   assign conf_data = acc_next;

endmodule

/* rtl/cel_queue.sv */
// cel_queue: short fifo of row confidences between front and log unit
// depends on cel_pkg

module cel_queue
   import cel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [CONF_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [CONF_W-1:0] pop_data,
   output logic              empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [CONF_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/cel_log.sv */
// cel_log: sequential -ln unit with result register, one row at a time
// depends on cel_pkg

module cel_log
   import cel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  logic [CONF_W-1:0] q_data,
   output logic              q_pop,
   output cel_rsp_type       rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   cel_log_state_type state_ff, state_in;
   logic [31:0]       y_ff, y_in;
   logic [4:0]        shift_ff, shift_in;
   logic [4:0]        iter_ff, iter_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [29:0]       n_ff, n_in;
   logic [61:0]       prod_ff, prod_in;
   cel_rsp_type       res_ff, res_in;
   cel_rsp_type       out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [63:0]       square;
   logic [32:0]       sq_scaled;
   logic [62:0]       rounded;
   logic [22:0]       loss_wide;
   logic              slot_free;

   assign square    = 64'(y_ff) * 64'(y_ff);
   assign sq_scaled = square[63:31];
   assign rounded   = 63'(prod_ff) + (63'(1) << 39);
   assign loss_wide = rounded[62:40];
   assign slot_free = ~out_valid_ff | rsp_pop;

   // sequencer: normalize, square 24 times, scale by ln 2, round; zero confidence goes straight to saturated loss
   always_comb begin
      state_in     = state_ff;
      y_in         = y_ff;
      shift_in     = shift_ff;
      iter_in      = iter_ff;
      frac_in      = frac_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      q_pop        = 1'b0;
      case (state_ff)
         LOG_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               y_in     = q_data;
               shift_in = '0;
               if (q_data == '0) begin
                  res_in.loss            = LOSS_MAX;
                  res_in.zero_confidence = 1'b1;
                  state_in               = LOG_DONE;
               end else begin
                  state_in = LOG_NORM;
               end
            end
         end
         LOG_NORM: begin
            if (y_ff[31]) begin
               iter_in  = '0;
               frac_in  = '0;
               state_in = LOG_SQUARE;
            end else begin
               y_in     = {y_ff[30:0], 1'b0};
               shift_in = shift_ff + 1'b1;
            end
         end
         LOG_SQUARE: begin
            frac_in = {frac_ff[FRAC_BITS-2:0], sq_scaled[32]};
            y_in    = sq_scaled[32] ? sq_scaled[32:1] : sq_scaled[31:0];
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 5'(FRAC_BITS - 1)) begin
               state_in = LOG_SUB;
            end
         end
         LOG_SUB: begin
            // -log2 in q.24: (leading zeros + 1) minus fractional log
            n_in     = ((30'(shift_ff) + 30'd1) << FRAC_BITS) - 30'(frac_ff);
            state_in = LOG_MUL;
         end
         LOG_MUL: begin
            prod_in  = 62'(n_ff) * 62'(LN2_Q32);
            state_in = LOG_ROUND;
         end
         LOG_ROUND: begin
            res_in.loss = (loss_wide > 23'(LOSS_MAX)) ? LOSS_MAX : loss_wide[19:0];
            res_in.zero_confidence = 1'b0;
            state_in = LOG_DONE;
         end
         LOG_DONE: begin
            if (slot_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = LOG_IDLE;
            end
         end
         default: begin
            state_in = LOG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOG_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      shift_ff <= shift_in;
      iter_ff  <= iter_in;
      frac_ff  <= frac_in;
      n_ff     <= n_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = ~out_valid_ff;

endmodule

/* rtl/cross_entropy_loss_row_unit.sv */
// cross_entropy_loss_row_unit: categorical cross-entropy loss per row of class
// probabilities. Front accepts one column per cycle while the queue has room.
// After a row's last column is accepted, the log unit runs the bit-wise normalize, the 24
// squaring steps, the ln 2 scaling and the rounding; zero confidence goes straight to the
// saturated loss. It takes one row at a time; a new result waits while the last is untaken.
// Long rows stream at one column per cycle; shorter ones run at one row per log pass.
// Synchronous active-high reset empties queue and result, clears row state, sets sparse mode.
// depends on cel_pkg, cel_front, cel_queue, cel_log

module cross_entropy_loss_row_unit
   import cel_pkg::*;
#(
   parameter int MAX_CLASSES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  cel_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output cel_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic              sparse_ff;
   logic              req_accept;
   logic              conf_push;
   logic [CONF_W-1:0] conf_data;
   logic              q_full, q_empty, q_pop;
   logic [CONF_W-1:0] q_data;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         sparse_ff <= 1'b1;
      end else if (csr_we) begin
         sparse_ff <= csr_wdata;
      end
   end

   assign req_full   = q_full;
   assign req_accept = req_push & ~q_full;

   cel_front #(
      .MAX_CLASSES(MAX_CLASSES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .sparse_labels(sparse_ff),
      .accept       (req_accept),
      .item         (req_data),
      .conf_push    (conf_push),
      .conf_data    (conf_data)
   );

   cel_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (conf_push),
      .push_data(conf_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty)
   );

   cel_log u_log (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop)
   );

   // a row confidence is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) conf_push |-> !q_full)
      else $error("row confidence pushed into full queue");

   // zero confidence always comes with saturated loss
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.zero_confidence) |-> (rsp_data.loss == LOSS_MAX))
      else $error("zero confidence without saturated loss");

   // a waiting result only goes away when it is taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result dropped without pop");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for cross_entropy_loss_row_unit, a table of directed rows
// followed by random rows in both label modes, checked against a predictor or fixed losses.
// depends on cel_pkg and the cross_entropy_loss_row_unit rtl

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cel_pkg::*;

   localparam int          NUM_CLASSES = 256;
   localparam logic [19:0] LOSS_SAT    = 20'hFFFFF;
   localparam logic [63:0] LN2_FIX     = 64'd2977044472;  // ln 2 in Q0.32
   localparam int          LOG_SETTLE  = 80;
   localparam int          HOLD_CYCLES = 600;
   localparam int          PHASE_ITEMS = 222;
   localparam int          NUM_PHASES  = 6;
   localparam int          MAX_REPORTS = 10;
   localparam logic        MODE_SPARSE = 1'b1;
   localparam logic        MODE_DENSE  = 1'b0;
   localparam logic        CHK_PRED    = 1'b0;
   localparam logic        CHK_FIXED   = 1'b1;

   // one row of the directed table
   typedef struct packed {
      logic        mode;
      logic [15:0] pred;
      logic [15:0] tgt;
      logic        last;
      logic        check;
      logic [19:0] loss;
      logic        zc;
   } directed_row_type;

   localparam directed_row_type DIRECTED [0:18] = '{
      // sparse: zero prediction clipped to one lsb at the matching column
      '{MODE_SPARSE, 16'h0000, 16'd0,     1'b1, CHK_FIXED, 20'd726817, 1'b0},
      // sparse: one half at column 1
      '{MODE_SPARSE, 16'h1234, 16'd1,     1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'h8000, 16'd1,     1'b1, CHK_FIXED, 20'd45426,  1'b0},
      // sparse: largest prediction
      '{MODE_SPARSE, 16'hFFFF, 16'd0,     1'b1, CHK_PRED,  20'd0,      1'b0},
      // sparse: class index out of range never matches
      '{MODE_SPARSE, 16'h4000, 16'd300,   1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'h4000, 16'hFFFF,  1'b1, CHK_FIXED, LOSS_SAT,   1'b1},
      // sparse: no column matched
      '{MODE_SPARSE, 16'h7777, 16'd5,     1'b1, CHK_FIXED, LOSS_SAT,   1'b1},
      // sparse: three column row, match at the end
      '{MODE_SPARSE, 16'h0001, 16'd2,     1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'h5555, 16'd2,     1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'hAAAA, 16'd2,     1'b1, CHK_PRED,  20'd0,      1'b0},
      // dense: accumulator saturates just below one
      '{MODE_DENSE,  16'hFFFF, 16'hFFFF,  1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_DENSE,  16'hFFFF, 16'hFFFF,  1'b1, CHK_PRED,  20'd0,      1'b0},
      // dense: all weights zero
      '{MODE_DENSE,  16'h1234, 16'd0,     1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_DENSE,  16'h0000, 16'd0,     1'b1, CHK_FIXED, LOSS_SAT,   1'b1},
      // dense: tiny confidence, loss beyond the Q4.16 range
      '{MODE_DENSE,  16'h0000, 16'd1,     1'b1, CHK_FIXED, LOSS_SAT,   1'b0},
      '{MODE_DENSE,  16'h8000, 16'h8000,  1'b1, CHK_PRED,  20'd0,      1'b0},
      // label mode switched in the middle of a row
      '{MODE_DENSE,  16'h2000, 16'h3000,  1'b0, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'h3000, 16'd1,     1'b1, CHK_PRED,  20'd0,      1'b0},
      '{MODE_SPARSE, 16'hABCD, 16'd0,     1'b1, CHK_PRED,  20'd0,      1'b0}
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   cel_req_type req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   cel_rsp_type rsp_data;
   logic        csr_we    = 1'b0;
   logic        csr_wdata = 1'b0;

   // predictor state
   logic        sparse_mode = MODE_SPARSE;
   int          column_idx  = 0;
   logic [31:0] confidence  = '0;

   cel_rsp_type loss_q [$];
   int          mismatches    = 0;
   int          rows_checked  = 0;
   int          zero_rows     = 0;
   int          sat_rows      = 0;
   int          full_cycles   = 0;
   int          items_sent    = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_req      = 1'b0;
   logic        hold_used     = 1'b0;
   int          hold_left     = 0;

   cross_entropy_loss_row_unit #(.MAX_CLASSES(NUM_CLASSES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -ln of a Q0.32 confidence as Q4.16, log2 by repeated squaring
   function automatic logic [19:0] neg_ln_loss(input logic [31:0] conf);
      int          top;
      int          i;
      logic [63:0] y;
      logic [63:0] frac;
      logic [63:0] whole;
      logic [63:0] nlog2;
      logic [63:0] scaled;
      top = 31;
      while (top > 0 && conf[top] == 1'b0) top--;
      y = {32'd0, conf} << (31 - top);
      frac = '0;
      for (i = 0; i < 24; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            y = y >> 1;
         end
      end
      whole = 64'(32 - top);
      nlog2 = (whole << 24) - frac;
      scaled = (nlog2 * LN2_FIX + (64'd1 << 39)) >> 40;
      if (scaled > {44'd0, LOSS_SAT}) scaled = {44'd0, LOSS_SAT};
      return scaled[19:0];
   endfunction

   // fold one column into the row confidence, returns 1 when the row closes
   function automatic logic accumulate_column(input cel_req_type it, output cel_rsp_type res);
      logic [15:0] p;
      logic [31:0] prod;
      logic [32:0] sum;
      p = (it.pred_prob == 16'd0) ? 16'd1 : it.pred_prob;
      res = '0;
      if (sparse_mode == MODE_SPARSE) begin
         if (int'(it.target) == column_idx) confidence = {p, 16'd0};
      end else begin
         prod = {16'd0, p} * {16'd0, it.target};
         sum = {1'b0, confidence} + {1'b0, prod};
         confidence = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      column_idx = (column_idx + 1) % NUM_CLASSES;
      if (!it.row_last) return 1'b0;
      res.zero_confidence = (confidence == 32'd0);
      res.loss = (confidence == 32'd0) ? LOSS_SAT : neg_ln_loss(confidence);
      column_idx = 0;
      confidence = '0;
      return 1'b1;
   endfunction

   // offer one column until accepted, then record the row's expected loss if it closes the row
   task automatic send_column(input cel_req_type it, input logic check,
                              input cel_rsp_type fixed_rsp);
      cel_rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (accumulate_column(it, res)) loss_q.push_back(check == CHK_FIXED ? fixed_rsp : res);
   endtask

   // stop offering until every pending loss has come out, then wait extra cycles
   task automatic settle_idle(input int extra);
      req_push <= 1'b0;
      do @(posedge clock); while (loss_q.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      settle_idle(LOG_SETTLE);
      csr_wdata <= mode;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      sparse_mode = mode;
   endtask

   // random rows: mostly well-formed with random content, some noise
   task automatic run_phase(input int n_items, input logic mode, input logic do_hold,
                            input int pause_at);
      int          sent;
      int          row_len;
      int          col;
      int          pick;
      int          style;
      int          hot_col;
      logic [15:0] row_target;
      cel_req_type it;
      write_mode(mode);
      if (do_hold) hold_req <= 1'b1;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         row_len = (pick < 88) ? $urandom_range(1, 12) :
                   (pick < 98) ? $urandom_range(13, 64) : $urandom_range(257, 300);
         style = $urandom_range(99);
         hot_col = $urandom_range(0, row_len - 1);
         if (mode == MODE_SPARSE) begin
            if (style < 75)
               row_target = 16'($urandom_range(0,
                               (row_len > NUM_CLASSES ? NUM_CLASSES : row_len) - 1));
            else if (style < 85)
               row_target = 16'($urandom_range(0, NUM_CLASSES - 1));
            else
               row_target = 16'($urandom_range(NUM_CLASSES, 65535));
         end else begin
            row_target = 16'($urandom_range(0, 65535));
         end
         for (col = 0; col < row_len && sent < n_items; col++) begin
            pick = $urandom_range(99);
            it.pred_prob = (pick < 8) ? 16'h0000 : (pick < 14) ? 16'hFFFF :
                           (pick < 18) ? 16'h0001 : 16'($urandom_range(0, 65535));
            if (mode == MODE_SPARSE)
               it.target = (style >= 93) ? 16'($urandom_range(0, 65535)) : row_target;
            else if (style < 15)
               it.target = 16'd0;
            else if (style < 55)
               it.target = (col == hot_col) ? row_target : 16'd0;
            else if (style < 85)
               it.target = 16'($urandom_range(0, 65535));
            else
               it.target = 16'($urandom_range(0, 15));
            it.row_last = (col == row_len - 1);
            send_column(it, CHK_PRED, '0);
            sent++;
            if (sent == pause_at) settle_idle(0);
         end
      end
   endtask

   // result side: check every accepted loss, random or held-off pop
   always @(posedge clock) begin : rsp_side
      cel_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (req_full) full_cycles++;
         if (rsp_pop && !rsp_empty) begin
            if (rsp_data.zero_confidence) zero_rows++;
            else if (rsp_data.loss == LOSS_SAT) sat_rows++;
            if (loss_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: loss %0d zero_confidence %0d",
                           rsp_data.loss, rsp_data.zero_confidence);
            end else begin
               want = loss_q.pop_front();
               rows_checked++;
               if (want.loss !== rsp_data.loss ||
                   want.zero_confidence !== rsp_data.zero_confidence) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("row %0d: loss exp %0d got %0d, zero_confidence exp %0d got %0d",
                              rows_checked, want.loss, rsp_data.loss,
                              want.zero_confidence, rsp_data.zero_confidence);
               end
            end
         end
         if (hold_req && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // stimulus: reset, directed table, then random phases
   initial begin : stim
      int          k;
      int          ph;
      cel_req_type it;
      cel_rsp_type fixed_rsp;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < $size(DIRECTED); k++) begin
         if (DIRECTED[k].mode != sparse_mode) write_mode(DIRECTED[k].mode);
         it.pred_prob = DIRECTED[k].pred;
         it.target    = DIRECTED[k].tgt;
         it.row_last  = DIRECTED[k].last;
         fixed_rsp.loss            = DIRECTED[k].loss;
         fixed_rsp.zero_confidence = DIRECTED[k].zc;
         send_column(it, DIRECTED[k].check, fixed_rsp);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 48 : 0;
         recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 11 : 0;
         run_phase(PHASE_ITEMS, (ph % 2) ? MODE_SPARSE : MODE_DENSE, ph == 4,
                   (ph == 5) ? PHASE_ITEMS / 2 : 0);
      end

      settle_idle(LOG_SETTLE);
      $display("sent %0d items over both label modes, checked %0d rows", items_sent,
               rows_checked);
      $display("%0d rows with zero confidence, %0d saturated, input stalled %0d cycles",
               zero_rows, sat_rows, full_cycles);
      if (mismatches == 0 && loss_q.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
